// ===== rtl/core/ang_pkg.sv =====
`default_nettype none

package ang_pkg;

    localparam int unsigned SAMPLE_WIDTH_DEF = 24;
    localparam int unsigned HOLD_WIDTH_DEF   = 17;
    localparam int unsigned CFG_IDX_WIDTH    = 4;

    localparam logic [18:0] LOG2_TO_DB_Q16 = 19'd394566;
    localparam logic [13:0] DB_TO_LOG2_Q16 = 14'd10885;
    localparam logic signed [15:0] DB_FLOOR_Q8 = -16'sd25600;

    localparam logic signed [15:0] THRESHOLD_RST = -16'sd10240;
    localparam logic [15:0] ATTACK_RST  = 16'd65262;
    localparam logic [15:0] RELEASE_RST = 16'd65524;
    localparam logic [15:0] SMOOTH_RST  = 16'd65263;
    localparam int unsigned HOLD_RST    = 1200;
    localparam logic [14:0] RANGE_RST   = 15'd15360;

    typedef enum logic [CFG_IDX_WIDTH-1:0] {
        REG_THRESHOLD,
        REG_ATTACK,
        REG_RELEASE,
        REG_SMOOTH,
        REG_HOLD,
        REG_RANGE,
        REG_MAKEUP,
        REG_STEREO
    } reg_idx_t;

    typedef struct packed {
        logic signed [15:0] threshold_db;
        logic [15:0]        attack_coeff;
        logic [15:0]        release_coeff;
        logic [15:0]        smooth_coeff;
        logic [14:0]        range_db;
        logic signed [13:0] makeup_db;
        logic               stereo_mode;
    } cfg_t;

    typedef enum logic [4:0] {
        OP_NOP,
        OP_LOAD,
        OP_ENV_MUL1,
        OP_ENV_MUL2,
        OP_ENV_SUM,
        OP_NORM,
        OP_SQ_MUL,
        OP_SQ_UPD,
        OP_DB_MUL,
        OP_DB_FIN,
        OP_GR_MUL1,
        OP_GR_MUL2,
        OP_GR_SUM,
        OP_EXP_MUL,
        OP_EXP_SPLIT,
        OP_POW_MUL,
        OP_POW_UPD,
        OP_SHIFT,
        OP_APP_LO,
        OP_APP_HI,
        OP_APP_FIN,
        OP_PUSH
    } op_t;

    typedef struct packed {
        op_t        op;
        logic [3:0] step;
        logic       ch;
    } cmd_t;

    typedef struct packed {
        logic stereo;
    } sts_t;

    typedef logic [31:0] root_tab_t [16];

    function automatic logic [63:0] isqrt64(input logic [63:0] v);
        logic [63:0] x;
        logic [63:0] r;
        logic [63:0] b;
        x = v;
        r = '0;
        b = 64'd1 << 62;
        while (b > x)
            b = b >> 2;
        while (b != 0)
        begin
            if (x >= r + b)
            begin
                x = x - (r + b);
                r = (r >> 1) + b;
            end
            else
            begin
                r = r >> 1;
            end
            b = b >> 2;
        end
        return r;
    endfunction

    // Chained square roots of 2.0 in Q30: entry k is 2^(2^-(k+1)).
    function automatic root_tab_t make_roots();
        root_tab_t   tab;
        logic [63:0] root;
        root = 64'd1 << 31;
        for (int k = 0; k < 16; k++)
        begin
            root = isqrt64(root << 30);
            tab[k] = root[31:0];
        end
        return tab;
    endfunction

endpackage

`default_nettype wire

// ===== rtl/core/ang_if.sv =====
`default_nettype none

interface ang_frame_if
    import ang_pkg::*;
#(
    parameter int unsigned SAMPLE_WIDTH = SAMPLE_WIDTH_DEF
);
    logic                           valid;
    logic                           ready;
    logic signed [SAMPLE_WIDTH-1:0] sample_left;
    logic signed [SAMPLE_WIDTH-1:0] sample_right;

    modport source (output valid, sample_left, sample_right, input ready);
    modport sink (input valid, sample_left, sample_right, output ready);
endinterface

interface ang_result_if
    import ang_pkg::*;
#(
    parameter int unsigned SAMPLE_WIDTH = SAMPLE_WIDTH_DEF
);
    logic                           valid;
    logic                           ready;
    logic signed [SAMPLE_WIDTH-1:0] out_left;
    logic signed [SAMPLE_WIDTH-1:0] out_right;
    logic signed [15:0]             gain_reduction_db;
    logic                           gate_open;

    modport source (output valid, out_left, out_right, gain_reduction_db, gate_open,
                    input ready);
    modport sink (input valid, out_left, out_right, gain_reduction_db, gate_open,
                  output ready);
endinterface

`default_nettype wire

// ===== rtl/core/ang_ctrl.sv =====
`default_nettype none

module ang_ctrl
    import ang_pkg::*;
(
    input  wire logic clk,
    input  wire logic rst_n,
    input  wire logic frame_valid,
    output logic      frame_ready,
    output logic      result_valid,
    input  wire logic result_ready,
    input  wire sts_t sts,
    output cmd_t      cmd
);

    typedef enum logic [4:0] {
        S_IDLE,
        S_ENV1,
        S_ENV2,
        S_ENV3,
        S_NORM,
        S_SQ_MUL,
        S_SQ_UPD,
        S_DB_MUL,
        S_DB_FIN,
        S_GR1,
        S_GR2,
        S_GR3,
        S_EXP_MUL,
        S_EXP_SPLIT,
        S_POW_MUL,
        S_POW_UPD,
        S_SHIFT,
        S_APP_LO,
        S_APP_HI,
        S_APP_FIN,
        S_PUSH
    } state_t;

    state_t     state_reg, state_next;
    logic [3:0] step_reg, step_next;
    logic       ch_reg, ch_next;
    logic       out_valid_reg, out_valid_next;
    logic       slot_free;

    assign slot_free    = !out_valid_reg || result_ready;
    assign frame_ready  = (state_reg == S_IDLE);
    assign result_valid = out_valid_reg;

    always_comb
    begin
        state_next = state_reg;
        step_next  = step_reg;
        ch_next    = ch_reg;
        cmd.op     = OP_NOP;
        cmd.step   = step_reg;
        cmd.ch     = ch_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (frame_valid)
                begin
                    cmd.op     = OP_LOAD;
                    state_next = S_ENV1;
                end
            end
            S_ENV1:
            begin
                cmd.op     = OP_ENV_MUL1;
                state_next = S_ENV2;
            end
            S_ENV2:
            begin
                cmd.op     = OP_ENV_MUL2;
                state_next = S_ENV3;
            end
            S_ENV3:
            begin
                cmd.op     = OP_ENV_SUM;
                step_next  = '0;
                state_next = S_NORM;
            end
            S_NORM:
            begin
                cmd.op = OP_NORM;
                if (step_reg == 4'd4)
                begin
                    step_next  = '0;
                    state_next = S_SQ_MUL;
                end
                else
                begin
                    step_next = step_reg + 4'd1;
                end
            end
            S_SQ_MUL:
            begin
                cmd.op     = OP_SQ_MUL;
                state_next = S_SQ_UPD;
            end
            S_SQ_UPD:
            begin
                cmd.op     = OP_SQ_UPD;
                step_next  = step_reg + 4'd1;
                state_next = (step_reg == 4'd15) ? S_DB_MUL : S_SQ_MUL;
            end
            S_DB_MUL:
            begin
                cmd.op     = OP_DB_MUL;
                state_next = S_DB_FIN;
            end
            S_DB_FIN:
            begin
                cmd.op     = OP_DB_FIN;
                state_next = S_GR1;
            end
            S_GR1:
            begin
                cmd.op     = OP_GR_MUL1;
                state_next = S_GR2;
            end
            S_GR2:
            begin
                cmd.op     = OP_GR_MUL2;
                state_next = S_GR3;
            end
            S_GR3:
            begin
                cmd.op     = OP_GR_SUM;
                state_next = S_EXP_MUL;
            end
            S_EXP_MUL:
            begin
                cmd.op     = OP_EXP_MUL;
                state_next = S_EXP_SPLIT;
            end
            S_EXP_SPLIT:
            begin
                cmd.op     = OP_EXP_SPLIT;
                step_next  = '0;
                state_next = S_POW_MUL;
            end
            S_POW_MUL:
            begin
                cmd.op     = OP_POW_MUL;
                state_next = S_POW_UPD;
            end
            S_POW_UPD:
            begin
                cmd.op     = OP_POW_UPD;
                step_next  = step_reg + 4'd1;
                state_next = (step_reg == 4'd15) ? S_SHIFT : S_POW_MUL;
            end
            S_SHIFT:
            begin
                cmd.op     = OP_SHIFT;
                ch_next    = 1'b0;
                state_next = S_APP_LO;
            end
            S_APP_LO:
            begin
                cmd.op     = OP_APP_LO;
                state_next = S_APP_HI;
            end
            S_APP_HI:
            begin
                cmd.op     = OP_APP_HI;
                state_next = S_APP_FIN;
            end
            S_APP_FIN:
            begin
                cmd.op = OP_APP_FIN;
                // run the right channel only in stereo
                if (!ch_reg && sts.stereo)
                begin
                    ch_next    = 1'b1;
                    state_next = S_APP_LO;
                end
                else
                begin
                    state_next = S_PUSH;
                end
            end
            S_PUSH:
            begin
                if (slot_free)
                begin
                    cmd.op     = OP_PUSH;
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_comb
    begin
        if (cmd.op == OP_PUSH)
            out_valid_next = 1'b1;
        else if (result_ready)
            out_valid_next = 1'b0;
        else
            out_valid_next = out_valid_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            step_reg      <= '0;
            ch_reg        <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            step_reg      <= step_next;
            ch_reg        <= ch_next;
            out_valid_reg <= out_valid_next;
        end
    end

    a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        (frame_valid && frame_ready) |=> !frame_ready)
        else $error("accepted a frame while busy");

    a_push_sets_valid: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.op == OP_PUSH) |=> result_valid)
        else $error("pushed result not presented");

    a_push_slot_free: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.op == OP_PUSH) |-> slot_free)
        else $error("result overwritten before taken");

    a_norm_steps: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_NORM) |-> (step_reg <= 4'd4))
        else $error("normalize step out of range");

endmodule

`default_nettype wire

// ===== rtl/core/ang_dp.sv =====
`default_nettype none

module ang_dp
    import ang_pkg::*;
#(
    parameter int unsigned SAMPLE_WIDTH = SAMPLE_WIDTH_DEF,
    parameter int unsigned HOLD_WIDTH   = HOLD_WIDTH_DEF
)
(
    input  wire logic                           clk,
    input  wire logic                           rst_n,
    input  wire cmd_t                           cmd,
    input  wire cfg_t                           cfg,
    input  wire logic [HOLD_WIDTH-1:0]          hold_samples,
    input  wire logic signed [SAMPLE_WIDTH-1:0] sample_left,
    input  wire logic signed [SAMPLE_WIDTH-1:0] sample_right,
    output logic signed [SAMPLE_WIDTH-1:0]      out_left,
    output logic signed [SAMPLE_WIDTH-1:0]      out_right,
    output logic signed [15:0]                  gain_reduction_db,
    output logic                                gate_open,
    output sts_t                                sts
);

    localparam int unsigned SW = SAMPLE_WIDTH;
    localparam root_tab_t   ROOTS = make_roots();
    localparam logic [67:0] MAXV  = (68'd1 << (SW - 1)) - 68'd1;

    logic [SW-1:0]       xl_reg, xr_reg, peak_reg;
    logic [31:0]         env_reg, env_next;
    logic                envz_reg;
    logic [31:0]         nval_reg, nval_next;
    logic [4:0]          msb_reg;
    logic [30:0]         m_reg;
    logic [15:0]         frac_reg;
    logic [HOLD_WIDTH-1:0] hold_reg, hold_next;
    logic                held_reg;
    logic [31:0]         gr_acc_reg;
    logic signed [15:0]  gr_q8_reg;
    logic                gopen_reg;
    logic signed [11:0]  n_reg;
    logic [23:0]         f_reg;
    logic                gz_reg;
    logic [31:0]         r_reg;
    logic [45:0]         g_reg;
    logic [SW-1:0]       outl_reg, outr_reg;
    logic signed [67:0]  prod_reg, acc_reg;

    logic [SW-1:0]       res_l_reg, res_r_reg;
    logic signed [15:0]  res_gr_reg;
    logic                res_open_reg;

    logic signed [33:0]  mul_a, mul_b;
    logic signed [67:0]  mul_p;
    logic                mul_en;

    logic [SW-1:0]       mag_l, mag_r, mag_x, x_sel;
    logic [15:0]         env_c;
    logic [16:0]         env_cm, smooth_cm;
    logic [5:0]          norm_sh;
    logic [31:0]         sq;
    logic signed [6:0]   l2_int;
    logic signed [22:0]  l2;
    logic [21:0]         db_negin;
    logic [67:0]         dsum;
    logic [17:0]         dbneg;
    logic signed [15:0]  db;
    logic                lvl_open;
    logic signed [32:0]  acc33;
    logic [32:0]         negacc;
    logic [67:0]         gsum;
    logic [32:0]         negnew;
    logic [33:0]         rq_t;
    logic [17:0]         rq, rqn;
    logic signed [17:0]  dbsum;
    logic signed [39:0]  bsd;
    logic [67:0]         psum;
    logic [4:0]          ns;
    logic [5:0]          rs;
    logic [51:0]         gs, gr_sum;
    logic [67:0]         lo_sum, pmag, pneg;
    logic [SW-1:0]       app_res;

    function automatic logic [SW-1:0] mag_of(input logic [SW-1:0] v);
        logic [SW-1:0] nv;
        nv = -v;
        return v[SW-1] ? nv : v;
    endfunction

    assign mag_l = mag_of(sample_left);
    assign mag_r = mag_of(sample_right);
    assign x_sel = cmd.ch ? xr_reg : xl_reg;
    assign mag_x = mag_of(x_sel);

    assign env_c     = (32'(peak_reg) > env_reg) ? cfg.attack_coeff : cfg.release_coeff;
    assign env_cm    = 17'h10000 - 17'(env_c);
    assign smooth_cm = 17'h10000 - 17'(cfg.smooth_coeff);

    // envelope, normalize and log2 mantissa
    assign env_next  = 32'(((acc_reg + prod_reg + 68'sd32768) >>> 16));
    assign norm_sh   = 6'd16 >> cmd.step;
    assign nval_next = ((nval_reg >> (6'd32 - norm_sh)) == 32'd0) ?
                       (nval_reg << norm_sh) : nval_reg;
    assign sq        = prod_reg[61:30];

    assign l2_int   = $signed({2'b00, msb_reg}) - 7'(SW - 1);
    assign l2       = {l2_int, frac_reg};
    assign db_negin = l2[22] ? 22'(-l2) : 22'd0;
    assign dsum     = prod_reg + 68'sd8388608;
    assign dbneg    = dsum[41:24];
    assign db       = (envz_reg || dbneg > 18'd25600) ? DB_FLOOR_Q8 : 16'(-dbneg);
    assign lvl_open = db >= cfg.threshold_db;

    always_comb
    begin
        if (lvl_open)
            hold_next = hold_samples;
        else if (hold_reg != '0)
            hold_next = hold_reg - 1'b1;
        else
            hold_next = hold_reg;
    end

    // gain reduction smoother
    assign acc33  = 33'($signed(gr_acc_reg));
    assign negacc = (acc33 > 33'sd0) ? 33'd0 : 33'(-acc33);
    assign gsum   = acc_reg + prod_reg + 68'sd32768;
    assign negnew = gsum[48:16];
    assign rq_t   = {1'b0, negnew} + 34'd32768;
    assign rq     = rq_t[33:16];
    assign rqn    = -rq;

    // exponent split and power chain
    assign dbsum = 18'(gr_q8_reg) + 18'(cfg.makeup_db);
    assign bsd   = $signed(prod_reg[39:0]) + 40'sh0040000000;
    assign psum  = prod_reg + 68'sd536870912;
    assign ns    = (n_reg > 12'sd20) ? 5'd20 : n_reg[4:0];
    assign rs    = 6'(-n_reg);

    always_comb
    begin
        if (gz_reg)
            gs = '0;
        else if (!n_reg[11])
            gs = 52'(r_reg) << ns;
        else if (n_reg < -12'sd40)
            gs = '0;
        else
            gs = 52'(r_reg) >> rs;
    end
    assign gr_sum = gs + 52'd32;

    // apply gain and saturate
    assign lo_sum = acc_reg + 68'sd8388608;
    assign pmag   = prod_reg + (lo_sum >> 24);
    assign pneg   = -pmag;

    always_comb
    begin
        if (x_sel[SW-1])
            app_res = (pmag > MAXV + 68'd1) ? {1'b1, {(SW-1){1'b0}}} : pneg[SW-1:0];
        else
            app_res = (pmag > MAXV) ? {1'b0, {(SW-1){1'b1}}} : pmag[SW-1:0];
    end

    always_comb
    begin
        mul_a  = '0;
        mul_b  = '0;
        mul_en = 1'b1;
        case (cmd.op)
            OP_ENV_MUL1:
            begin
                mul_a = 34'(env_reg);
                mul_b = 34'(env_c);
            end
            OP_ENV_MUL2:
            begin
                mul_a = 34'(env_cm);
                mul_b = 34'(peak_reg);
            end
            OP_SQ_MUL:
            begin
                mul_a = 34'(m_reg);
                mul_b = 34'(m_reg);
            end
            OP_DB_MUL:
            begin
                mul_a = 34'(db_negin);
                mul_b = 34'(LOG2_TO_DB_Q16);
            end
            OP_GR_MUL1:
            begin
                mul_a = 34'(negacc);
                mul_b = 34'(cfg.smooth_coeff);
            end
            OP_GR_MUL2:
            begin
                mul_a = 34'(smooth_cm);
                mul_b = held_reg ? 34'sd0 : 34'({cfg.range_db, 16'h0000});
            end
            OP_EXP_MUL:
            begin
                mul_a = 34'(dbsum);
                mul_b = 34'(DB_TO_LOG2_Q16);
            end
            OP_POW_MUL:
            begin
                mul_a = 34'(r_reg);
                mul_b = 34'(ROOTS[cmd.step]);
            end
            OP_APP_LO:
            begin
                mul_a = 34'(mag_x);
                mul_b = 34'(g_reg[23:0]);
            end
            OP_APP_HI:
            begin
                mul_a = 34'(mag_x);
                mul_b = 34'(g_reg[45:24]);
            end
            default:
            begin
                mul_en = 1'b0;
            end
        endcase
    end
    assign mul_p = mul_a * mul_b;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            env_reg    <= '0;
            hold_reg   <= '0;
            gr_acc_reg <= '0;
        end
        else
        begin
            if (cmd.op == OP_ENV_SUM)
                env_reg <= env_next;
            if (cmd.op == OP_DB_FIN)
                hold_reg <= hold_next;
            if (cmd.op == OP_GR_SUM)
                gr_acc_reg <= 32'(-negnew);
        end
    end

    always_ff @(posedge clk)
    begin
        if (mul_en)
            prod_reg <= mul_p;
        if (cmd.op == OP_ENV_MUL2 || cmd.op == OP_GR_MUL2 || cmd.op == OP_APP_HI)
            acc_reg <= prod_reg;
        case (cmd.op)
            OP_LOAD:
            begin
                xl_reg   <= sample_left;
                xr_reg   <= sample_right;
                peak_reg <= (cfg.stereo_mode && mag_r > mag_l) ? mag_r : mag_l;
            end
            OP_ENV_SUM:
            begin
                nval_reg <= env_next;
                envz_reg <= (env_next == 32'd0);
                msb_reg  <= 5'd31;
            end
            OP_NORM:
            begin
                nval_reg <= nval_next;
                if (nval_next != nval_reg)
                    msb_reg <= msb_reg - norm_sh[4:0];
                m_reg    <= nval_next[31:1];
                frac_reg <= '0;
            end
            OP_SQ_UPD:
            begin
                frac_reg <= {frac_reg[14:0], sq[31]};
                m_reg    <= sq[31] ? sq[31:1] : sq[30:0];
            end
            OP_DB_FIN:
            begin
                held_reg <= lvl_open || (hold_next != '0);
            end
            OP_GR_SUM:
            begin
                gr_q8_reg <= rqn[15:0];
                gopen_reg <= negnew < 33'h001000000;
            end
            OP_EXP_SPLIT:
            begin
                gz_reg <= bsd[39];
                n_reg  <= $signed({1'b0, bsd[34:24]}) - 12'sd64;
                f_reg  <= bsd[23:0];
                r_reg  <= 32'h40000000;
            end
            OP_POW_UPD:
            begin
                if (f_reg[5'd23 - 5'(cmd.step)])
                    r_reg <= psum[61:30];
            end
            OP_SHIFT:
            begin
                g_reg <= gr_sum[51:6];
            end
            OP_APP_FIN:
            begin
                if (cmd.ch)
                    outr_reg <= app_res;
                else
                    outl_reg <= app_res;
            end
            OP_PUSH:
            begin
                res_l_reg    <= outl_reg;
                res_r_reg    <= cfg.stereo_mode ? outr_reg : '0;
                res_gr_reg   <= gr_q8_reg;
                res_open_reg <= gopen_reg;
            end
            default:
            begin
            end
        endcase
    end

    assign out_left          = res_l_reg;
    assign out_right         = res_r_reg;
    assign gain_reduction_db = res_gr_reg;
    assign gate_open         = res_open_reg;
    assign sts.stereo        = cfg.stereo_mode;

    a_gr_nonpositive: assert property (@(posedge clk) disable iff (!rst_n)
        (gr_acc_reg == 32'd0) || gr_acc_reg[31])
        else $error("gain reduction accumulator went positive");

    a_mantissa_norm: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.op == OP_SQ_MUL && !envz_reg) |-> m_reg[30])
        else $error("log mantissa not normalized");

    a_env_zero_flag: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.op == OP_ENV_SUM) |=> (envz_reg == (env_reg == 32'd0)))
        else $error("envelope zero flag out of step");

endmodule

`default_nettype wire

// ===== rtl/core/audio_noise_gate_core.sv =====
// Noise gate with hold and range for one frame of up to two linked channels.
//
// frame carries one stereo (or mono) Q1.23 frame; result returns the gated
// samples, the smoothed gain reduction in Q7.8 dB and the gate-open flag.
// Both are valid/ready channels; a transaction completes when valid and
// ready are high at a rising edge. The user must write registers through
// cfg_we/cfg_index/cfg_wdata only while the block is idle; the block does
// not enforce this itself. Unknown indexes drop.
//
// A single shared 34x34 multiplier runs the envelope, a 16-step log2
// squaring loop, the smoother, a 16-step power-of-two chain and the gain
// products one at a time. A new frame is taken only once the last result
// has been pushed to the output register.
// A finished result sits in the output register; the next frame is taken
// while it waits, and the datapath holds its new result until the slot is
// free, so a stalled receiver stops intake after at most one more frame.
// Reset clears the envelope, hold counter, gain reduction and all control
// state, and loads the register defaults.
`default_nettype none

module audio_noise_gate_core
    import ang_pkg::*;
#(
    parameter int unsigned SAMPLE_WIDTH = SAMPLE_WIDTH_DEF,
    parameter int unsigned HOLD_WIDTH   = HOLD_WIDTH_DEF
)
(
    input  wire logic                                     clk,
    input  wire logic                                     rst_n,
    input  wire logic                                     cfg_we,
    input  wire logic [CFG_IDX_WIDTH-1:0]                 cfg_index,
    input  wire logic [(HOLD_WIDTH > 16 ? HOLD_WIDTH : 16)-1:0] cfg_wdata,
    ang_frame_if.sink                                     frame,
    ang_result_if.source                                  result
);

    cfg_t                  cfg_reg;
    logic [HOLD_WIDTH-1:0] hold_reg;
    cmd_t                  cmd;
    sts_t                  sts;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.threshold_db  <= THRESHOLD_RST;
            cfg_reg.attack_coeff  <= ATTACK_RST;
            cfg_reg.release_coeff <= RELEASE_RST;
            cfg_reg.smooth_coeff  <= SMOOTH_RST;
            cfg_reg.range_db      <= RANGE_RST;
            cfg_reg.makeup_db     <= '0;
            cfg_reg.stereo_mode   <= 1'b1;
            hold_reg              <= HOLD_WIDTH'(HOLD_RST);
        end
        else if (cfg_we)
        begin
            unique case (reg_idx_t'(cfg_index))
                REG_THRESHOLD: cfg_reg.threshold_db  <= cfg_wdata[15:0];
                REG_ATTACK:    cfg_reg.attack_coeff  <= cfg_wdata[15:0];
                REG_RELEASE:   cfg_reg.release_coeff <= cfg_wdata[15:0];
                REG_SMOOTH:    cfg_reg.smooth_coeff  <= cfg_wdata[15:0];
                REG_HOLD:      hold_reg              <= cfg_wdata[HOLD_WIDTH-1:0];
                REG_RANGE:     cfg_reg.range_db      <= cfg_wdata[14:0];
                REG_MAKEUP:    cfg_reg.makeup_db     <= cfg_wdata[13:0];
                REG_STEREO:    cfg_reg.stereo_mode   <= cfg_wdata[0];
                default:
                begin
                end
            endcase
        end
    end

    ang_ctrl u_ctrl (
        .clk          (clk),
        .rst_n        (rst_n),
        .frame_valid  (frame.valid),
        .frame_ready  (frame.ready),
        .result_valid (result.valid),
        .result_ready (result.ready),
        .sts          (sts),
        .cmd          (cmd)
    );

    ang_dp #(
        .SAMPLE_WIDTH (SAMPLE_WIDTH),
        .HOLD_WIDTH   (HOLD_WIDTH)
    ) u_dp (
        .clk               (clk),
        .rst_n             (rst_n),
        .cmd               (cmd),
        .cfg               (cfg_reg),
        .hold_samples      (hold_reg),
        .sample_left       (frame.sample_left),
        .sample_right      (frame.sample_right),
        .out_left          (result.out_left),
        .out_right         (result.out_right),
        .gain_reduction_db (result.gain_reduction_db),
        .gate_open         (result.gate_open),
        .sts               (sts)
    );

endmodule

`default_nettype wire

// ===== tb/audio_noise_gate_core_tb.sv =====
`default_nettype none

module audio_noise_gate_core_tb;
    import ang_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int SW = 24;
    localparam logic [CFG_IDX_WIDTH-1:0] UNUSED_IDX = '1;

    typedef struct {
        logic signed [SW-1:0] left;
        logic signed [SW-1:0] right;
        logic signed [15:0]   gr_db;
        logic                 open;
    } gate_out_t;

    typedef struct {
        logic signed [SW-1:0] left;
        logic signed [SW-1:0] right;
        logic                 typed;
    } frame_row_t;

    logic                       clk;
    logic                       rst_n;
    logic                       cfg_we;
    logic [CFG_IDX_WIDTH-1:0]   cfg_index;
    logic [16:0]                cfg_wdata;

    ang_frame_if  #(.SAMPLE_WIDTH(SW)) frame_ch ();
    ang_result_if #(.SAMPLE_WIDTH(SW)) result_ch ();

    audio_noise_gate_core uut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .frame     (frame_ch),
        .result    (result_ch)
    );

    // gate settings as the predictor sees them
    logic signed [15:0] thr_db;
    logic [15:0]        att_c, rel_c, smo_c;
    logic [16:0]        hold_len;
    logic [14:0]        depth_db;
    logic signed [13:0] makeup;
    logic               stereo;

    // gate state
    logic [31:0] env_level;
    logic [16:0] hold_left;
    logic [31:0] gr_acc;

    logic [63:0] sqrt2_chain [16];
    gate_out_t   pending_q [$];
    int          err_count;
    logic        no_idle;
    logic        hold_off_req;

    // loudness walk for the random frames
    int burst_shift;
    int burst_left;

    always
    begin
        clk = 1'b0;
        #5;
        clk = 1'b1;
        #5;
    end

    initial
    begin
        #10ms;
        $display("[audio_noise_gate_core] ERROR");
        $finish;
    end

    task automatic report(input string what, input longint got, input longint want);
        $display("mismatch %s: got %0d want %0d at %0t", what, got, want, $realtime);
        err_count++;
    endtask

    function automatic logic [63:0] int_sqrt(input logic [63:0] v);
        logic [63:0] x, r, b;
        x = v;
        r = 0;
        b = 64'd1 << 62;
        while (b > x)
            b = b >> 2;
        while (b != 0)
        begin
            if (x >= r + b)
            begin
                x = x - (r + b);
                r = (r >> 1) + b;
            end
            else
                r = r >> 1;
            b = b >> 2;
        end
        return r;
    endfunction

    function automatic longint env_to_db(input logic [31:0] e);
        int          msb;
        logic [63:0] m, frac, neg, dbneg;
        longint      l2, db;
        if (e == 0)
            return DB_FLOOR_Q8;
        msb = 0;
        while (msb < 31 && (e >> (msb + 1)) != 0)
            msb++;
        m = (msb <= 30) ? (64'(e) << (30 - msb)) : (64'(e) >> (msb - 30));
        frac = 0;
        for (int k = 0; k < 16; k++)
        begin
            m = (m * m) >> 30;
            frac = frac << 1;
            if (m >= (64'd1 << 31))
            begin
                frac = frac | 1;
                m = m >> 1;
            end
        end
        l2 = longint'(msb - (SW - 1)) * 65536 + longint'(frac);
        if (l2 > 0)
            l2 = 0;
        neg = 64'(-l2);
        dbneg = (neg * 64'(LOG2_TO_DB_Q16) + (64'd1 << 23)) >> 24;
        db = -longint'(dbneg);
        return (db < DB_FLOOR_Q8) ? longint'(DB_FLOOR_Q8) : db;
    endfunction

    function automatic logic [63:0] db_to_gain(input longint db_q8);
        longint      biased, n;
        logic [63:0] f, r, g;
        biased = db_q8 * longint'(DB_TO_LOG2_Q16) + (longint'(64) << 24);
        if (biased < 0)
            return 0;
        n = (biased >>> 24) - 64;
        f = 64'(biased) & 64'hFFFFFF;
        r = 64'd1 << 30;
        for (int k = 1; k <= 16; k++)
            if (f[24 - k])
                r = (r * sqrt2_chain[k - 1] + (64'd1 << 29)) >> 30;
        if (n >= 0)
        begin
            if (n > 20)
                n = 20;
            g = r << n;
        end
        else
        begin
            if (n < -40)
                return 0;
            g = r >> (-n);
        end
        return (g + 32) >> 6;
    endfunction

    function automatic logic [SW-1:0] scale_sample(input longint x, input logic [63:0] g);
        logic [63:0] mag, p;
        longint      maxv;
        mag = 64'(x < 0 ? -x : x);
        p = (mag * g + (64'd1 << 23)) >> 24;
        maxv = (longint'(1) << (SW - 1)) - 1;
        if (x < 0)
            return (p > 64'(maxv + 1)) ? SW'(-maxv - 1) : SW'(-longint'(p));
        return (p > 64'(maxv)) ? SW'(maxv) : SW'(p);
    endfunction

    function automatic gate_out_t gate_frame(input logic signed [SW-1:0] xl,
                                             input logic signed [SW-1:0] xr);
        gate_out_t   o;
        longint      l, r, acc, tgt, db, gr;
        logic [63:0] peak, c, nenv, sum, negnew, g;
        logic        open, held;
        l = xl;
        r = xr;
        peak = 64'(l < 0 ? -l : l);
        if (stereo && 64'(r < 0 ? -r : r) > peak)
            peak = 64'(r < 0 ? -r : r);
        c = (peak > 64'(env_level)) ? 64'(att_c) : 64'(rel_c);
        nenv = (c * 64'(env_level) + (64'd65536 - c) * peak + 32768) >> 16;
        env_level = nenv[31:0];

        db = env_to_db(env_level);
        open = db >= longint'(thr_db);
        if (open)
            hold_left = hold_len;
        else if (hold_left > 0)
            hold_left = hold_left - 1;
        held = open || hold_left > 0;

        tgt = held ? 0 : -longint'(depth_db);
        acc = longint'($signed(gr_acc));
        if (acc > 0)
            acc = 0;
        c = 64'(smo_c);
        sum = c * 64'(-acc) + (64'd65536 - c) * (64'(-tgt) << 16);
        negnew = (sum + 32768) >> 16;
        gr_acc = 32'(-longint'(negnew));

        gr = -longint'((negnew + 32768) >> 16);
        g = db_to_gain(gr + longint'(makeup));
        o.left = scale_sample(l, g);
        o.right = stereo ? scale_sample(r, g) : '0;
        o.gr_db = 16'(gr);
        o.open = negnew < (64'd256 << 16);
        return o;
    endfunction

    // drop the offer so nothing new enters, then let every result come back
    task automatic wait_drained();
        frame_ch.valid = 1'b0;
        while (pending_q.size() != 0)
            @(negedge clk);
        repeat (100) @(negedge clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_WIDTH-1:0] idx, input logic [16:0] val);
        cfg_we = 1'b1;
        cfg_index = idx;
        cfg_wdata = val;
        case (idx)
            REG_THRESHOLD: thr_db = val[15:0];
            REG_ATTACK:    att_c = val[15:0];
            REG_RELEASE:   rel_c = val[15:0];
            REG_SMOOTH:    smo_c = val[15:0];
            REG_HOLD:      hold_len = val;
            REG_RANGE:     depth_db = val[14:0];
            REG_MAKEUP:    makeup = val[13:0];
            REG_STEREO:    stereo = val[0];
            default: ;
        endcase
        @(negedge clk);
        cfg_we = 1'b0;
    endtask

    task automatic load_settings(input int thr, input int att, input int rel, input int smo,
                                 input int hold, input int rng, input int mk, input int st);
        wait_drained();
        write_reg(REG_THRESHOLD, 17'(thr));
        write_reg(REG_ATTACK, 17'(att));
        write_reg(REG_RELEASE, 17'(rel));
        write_reg(REG_SMOOTH, 17'(smo));
        write_reg(REG_HOLD, 17'(hold));
        write_reg(REG_RANGE, 17'(rng));
        write_reg(REG_MAKEUP, 17'(mk));
        write_reg(REG_STEREO, 17'(st));
    endtask

    // called at a falling edge; returns at the falling edge after the transaction
    task automatic send_frame(input logic signed [SW-1:0] l, input logic signed [SW-1:0] r,
                              input logic typed, input gate_out_t want);
        gate_out_t pred;
        while (!no_idle && $urandom_range(99) < 14)
        begin
            frame_ch.valid = 1'b0;
            @(negedge clk);
        end
        frame_ch.valid = 1'b1;
        frame_ch.sample_left = l;
        frame_ch.sample_right = r;
        @(posedge clk);
        while (!frame_ch.ready)
            @(posedge clk);
        pred = gate_frame(l, r);
        if (typed)
            pred = want;
        pending_q = {pending_q, pred};
        @(negedge clk);
    endtask

    function automatic logic signed [SW-1:0] noisy_sample();
        logic signed [SW-1:0] s;
        if ($urandom_range(99) < 3)
            return SW'($urandom);
        s = SW'($urandom);
        return s >>> burst_shift;
    endfunction

    task automatic random_frames(input int count, input int hold_at, input int pause_at);
        gate_out_t none;
        none = '{default: '0};
        for (int i = 0; i < count; i++)
        begin
            if (burst_left == 0)
            begin
                burst_shift = $urandom_range(0, 23);
                burst_left = $urandom_range(5, 60);
            end
            burst_left--;
            if (i == hold_at)
                hold_off_req = 1'b1;
            if (i == pause_at)
            begin
                frame_ch.valid = 1'b0;
                while (pending_q.size() != 0)
                    @(negedge clk);
            end
            send_frame(noisy_sample(), noisy_sample(), 1'b0, none);
        end
    endtask

    // receiver: random stalls, plus one long hold-off on request
    initial
    begin
        int stall;
        result_ch.ready = 1'b0;
        stall = 0;
        forever
        begin
            @(negedge clk);
            if (hold_off_req)
            begin
                hold_off_req = 1'b0;
                stall = 400;
            end
            if (stall > 0)
            begin
                stall--;
                result_ch.ready = 1'b0;
            end
            else
                result_ch.ready = no_idle || ($urandom_range(99) >= 14);
        end
    end

    // check each result transaction against the oldest expectation
    initial
    begin
        gate_out_t want;
        forever
        begin
            @(posedge clk);
            if (rst_n && result_ch.valid && result_ch.ready)
            begin
                if (pending_q.size() == 0)
                begin
                    $display("unexpected result at %0t", $realtime);
                    err_count++;
                end
                else
                begin
                    want = pending_q.pop_front();
                    if (result_ch.out_left !== want.left)
                        report("out_left", result_ch.out_left, want.left);
                    if (result_ch.out_right !== want.right)
                        report("out_right", result_ch.out_right, want.right);
                    if (result_ch.gain_reduction_db !== want.gr_db)
                        report("gain_reduction_db", result_ch.gain_reduction_db, want.gr_db);
                    if (result_ch.gate_open !== want.open)
                        report("gate_open", result_ch.gate_open, want.open);
                end
            end
        end
    end

    initial
    begin
        frame_row_t rows [14];
        gate_out_t  want;
        logic [63:0] root;

        rows = '{
            '{24'sd0, 24'sd0, 1'b1},
            '{24'sh7FFFFF, -24'sh800000, 1'b1},
            '{-24'sh800000, 24'sh7FFFFF, 1'b1},
            '{-24'sd1, 24'sd1, 1'b1},
            '{24'sd1, -24'sd1, 1'b1},
            '{24'sh555555, -24'sh555556, 1'b1},
            '{-24'sh2AAAAB, 24'sh2AAAAA, 1'b1},
            '{24'sh7FFFFF, 24'sh7FFFFF, 1'b1},
            '{-24'sh800000, -24'sh800000, 1'b1},
            '{24'sh000100, 24'sh400000, 1'b0},
            '{24'sd0, 24'sd0, 1'b1},
            '{24'sh123456, -24'sh654321, 1'b0},
            '{-24'sh7FFFFF, 24'sd0, 1'b1},
            '{24'sd0, -24'sh7FFFFF, 1'b1}
        };

        root = 64'd1 << 31;
        for (int k = 0; k < 16; k++)
        begin
            root = int_sqrt(root << 30);
            sqrt2_chain[k] = root;
        end

        rst_n = 1'b0;
        cfg_we = 1'b0;
        cfg_index = '0;
        cfg_wdata = '0;
        frame_ch.valid = 1'b0;
        frame_ch.sample_left = '0;
        frame_ch.sample_right = '0;
        err_count = 0;
        no_idle = 1'b0;
        hold_off_req = 1'b0;
        burst_shift = 0;
        burst_left = 0;

        thr_db = THRESHOLD_RST;
        att_c = ATTACK_RST;
        rel_c = RELEASE_RST;
        smo_c = SMOOTH_RST;
        hold_len = 17'(HOLD_RST);
        depth_db = RANGE_RST;
        makeup = '0;
        stereo = 1'b1;
        env_level = '0;
        hold_left = '0;
        gr_acc = '0;

        repeat (9) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        random_frames(100, -1, -1);

        // unity path: no range, instant smoothing, no makeup -> output equals input
        load_settings(-10240, 65262, 65524, 0, 1200, 0, 0, 1);
        write_reg(UNUSED_IDX, 17'h1FFFF);
        foreach (rows[i])
        begin
            want.left = rows[i].left;
            want.right = rows[i].right;
            want.gr_db = '0;
            want.open = 1'b1;
            send_frame(rows[i].left, rows[i].right, rows[i].typed, want);
        end

        // mono, zero hold, deepest range, maximum makeup
        load_settings(-10240, 40000, 60000, 50000, 0, 20480, 6144, 0);
        random_frames(150, -1, -1);
        // instant coefficients, range beyond its stated bound, minimum makeup
        load_settings(-20480, 0, 0, 0, 3, 32767, -3072, 1);
        random_frames(150, 50, -1);
        // slowest coefficients, longest hold, zero threshold
        load_settings(0, 65535, 65535, 65535, 131071, 0, 0, 1);
        random_frames(150, -1, 70);
        no_idle = 1'b1;
        load_settings(-5000, 30000, 64000, 60000, 20, 12000, 3000, 1);
        random_frames(150, -1, -1);
        no_idle = 1'b0;
        for (int p = 0; p < 3; p++)
        begin
            load_settings(-int'($urandom_range(20480)), $urandom_range(65535),
                          $urandom_range(65535), $urandom_range(65535),
                          $urandom_range(60), $urandom_range(20480),
                          int'($urandom_range(9216)) - 3072, $urandom_range(1));
            random_frames(150, (p == 1) ? 40 : -1, -1);
        end

        frame_ch.valid = 1'b0;
        while (pending_q.size() != 0)
            @(negedge clk);
        repeat (200) @(posedge clk);
        if (err_count == 0)
            $display("[audio_noise_gate_core] OK");
        else
            $display("[audio_noise_gate_core] ERROR");
        $finish;
    end

endmodule

`default_nettype wire
